// File: sv/cdq_pkg.sv
package cdq_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    MODE_PUSH_BACK  = 2'd0,
    MODE_PUSH_FRONT = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_BACK   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // Shift command that is broadcast along the row of cells.
  typedef struct packed {
    logic  en;
    mode_t mode;
  } cell_ctrl_t;

endpackage

// File: sv/circular_deque_core.sv
// Bounded double-ended queue of DEPTH 32-bit entries held in a row of cells, front at
// cell zero and entries packed toward it. Every transaction gives
// exactly one result (popped value, status, entry count after the operation) in the cycle
// after it is accepted, through an output register, so a new transaction is accepted in every cycle in
// which the result register is empty or being taken. Front operations shift the whole
// row by one cell; back operations touch only the last occupied cell or the first free cell after it,
// and a pop from the back selects the last occupied cell's value across the row.
module circular_deque_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [1:0]                             in_mode,
  input  logic signed [cdq_pkg::DATA_W-1:0]      in_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [cdq_pkg::DATA_W-1:0]      out_popped_value,
  output logic [1:0]                             out_status,
  output logic [$clog2(DEPTH+1)-1:0]             out_entry_count
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic signed [cdq_pkg::DATA_W-1:0] cell_data  [DEPTH];
  logic                              cell_valid [DEPTH];
  logic                              cell_last  [DEPTH];

  logic [CNT_W-1:0]                  count_r;
  logic [CNT_W-1:0]                  count_nxt;
  logic                              out_valid_r;
  logic signed [cdq_pkg::DATA_W-1:0] out_popped_value_r;
  logic signed [cdq_pkg::DATA_W-1:0] popped_nxt;
  cdq_pkg::status_t                  out_status_r;
  cdq_pkg::status_t                  status_nxt;
  logic [CNT_W-1:0]                  out_entry_count_r;
  logic signed [cdq_pkg::DATA_W-1:0] back_value;
  cdq_pkg::mode_t                    mode;
  cdq_pkg::cell_ctrl_t               ctrl;
  logic                              accept;
  logic                              is_full;
  logic                              is_empty;

  assign mode     = cdq_pkg::mode_t'(in_mode);
  assign in_ready = ~out_valid_r | out_ready;
  assign accept   = in_valid & in_ready;
  assign is_full  = (count_r == FULL_CNT);
  assign is_empty = (count_r == '0);

  always_comb begin
    back_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_value = back_value | (cell_last[i] ? cell_data[i] : '0);
    end
  end

  always_comb begin
    count_nxt  = count_r;
    popped_nxt = '0;
    status_nxt = cdq_pkg::STATUS_OK;
    ctrl.mode  = mode;
    ctrl.en    = 1'b0;
    case (mode)
      cdq_pkg::MODE_PUSH_BACK,
      cdq_pkg::MODE_PUSH_FRONT: begin
        if (is_full) begin
          status_nxt = cdq_pkg::STATUS_FULL;
        end else begin
          ctrl.en   = accept;
          count_nxt = count_r + 1'b1;
        end
      end
      cdq_pkg::MODE_POP_FRONT: begin
        if (is_empty) begin
          status_nxt = cdq_pkg::STATUS_EMPTY;
        end else begin
          ctrl.en    = accept;
          count_nxt  = count_r - 1'b1;
          popped_nxt = cell_data[0];
        end
      end
      cdq_pkg::MODE_POP_BACK: begin
        if (is_empty) begin
          status_nxt = cdq_pkg::STATUS_EMPTY;
        end else begin
          ctrl.en    = accept;
          count_nxt  = count_r - 1'b1;
          popped_nxt = back_value;
        end
      end
      default: begin
        status_nxt = cdq_pkg::STATUS_OK;
      end
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [cdq_pkg::DATA_W-1:0] l_data;
    logic                              l_valid;
    logic signed [cdq_pkg::DATA_W-1:0] r_data;
    logic                              r_valid;

    if (g == 0) begin : g_head
      assign l_data  = in_value;
      assign l_valid = 1'b1;
    end else begin : g_mid
      assign l_data  = cell_data[g-1];
      assign l_valid = cell_valid[g-1];
    end

    if (g == DEPTH - 1) begin : g_end
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_data  = cell_data[g+1];
      assign r_valid = cell_valid[g+1];
    end

    cdq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .push_value  (in_value),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .right_data  (r_data),
      .right_valid (r_valid),
      .data        (cell_data[g]),
      .valid       (cell_valid[g]),
      .last        (cell_last[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_popped_value_r <= popped_nxt;
      out_status_r       <= status_nxt;
      out_entry_count_r  <= count_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = out_popped_value_r;
  assign out_status       = out_status_r;
  assign out_entry_count  = out_entry_count_r;

endmodule

// File: sv/cdq_cell.sv
module cdq_cell (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  cdq_pkg::cell_ctrl_t                   ctrl,
  input  logic signed [cdq_pkg::DATA_W-1:0]     push_value,
  input  logic signed [cdq_pkg::DATA_W-1:0]     left_data,
  input  logic                                  left_valid,
  input  logic signed [cdq_pkg::DATA_W-1:0]     right_data,
  input  logic                                  right_valid,
  output logic signed [cdq_pkg::DATA_W-1:0]     data,
  output logic                                  valid,
  output logic                                  last
);

  logic signed [cdq_pkg::DATA_W-1:0] data_r;
  logic signed [cdq_pkg::DATA_W-1:0] data_nxt;
  logic                              valid_r;
  logic                              valid_nxt;
  logic                              first_free;

  assign first_free = left_valid & ~valid_r;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (ctrl.en) begin
      case (ctrl.mode)
        cdq_pkg::MODE_PUSH_BACK: begin
          if (first_free) begin
            data_nxt  = push_value;
            valid_nxt = 1'b1;
          end
        end
        cdq_pkg::MODE_PUSH_FRONT: begin
          data_nxt  = left_data;
          valid_nxt = left_valid;
        end
        cdq_pkg::MODE_POP_FRONT: begin
          data_nxt  = right_data;
          valid_nxt = right_valid;
        end
        cdq_pkg::MODE_POP_BACK: begin
          if (last) begin
            valid_nxt = 1'b0;
          end
        end
        default: begin
          valid_nxt = valid_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data  = data_r;
  assign valid = valid_r;
  assign last  = valid_r & ~right_valid;

endmodule

// File: sim/tb_circular_deque_core.sv
module tb_circular_deque_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 60;
  localparam int RANDOM_ITEMS = 200;
  localparam int REPORT_MAX = 10;
  localparam int SETTLE_CYCLES = 10;

  typedef struct packed {
    logic [cdq_pkg::DATA_W-1:0] popped;
    cdq_pkg::status_t           status;
    logic [CNT_W-1:0]           count;
  } deque_result_t;

  typedef struct packed {
    cdq_pkg::mode_t             mode;
    logic [cdq_pkg::DATA_W-1:0] value;
    logic                       fixed;
    deque_result_t              want;
  } stim_row_t;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_ready;
  cdq_pkg::mode_t                    in_mode;
  logic signed [cdq_pkg::DATA_W-1:0] in_value;
  logic                              out_valid;
  logic                              out_ready;
  logic signed [cdq_pkg::DATA_W-1:0] out_popped_value;
  logic [1:0]                        out_status;
  logic [CNT_W-1:0]                  out_entry_count;

  logic [cdq_pkg::DATA_W-1:0] dq_mem [DEPTH];
  logic [PTR_W-1:0]           dq_head;
  logic [PTR_W-1:0]           dq_tail;
  logic [CNT_W-1:0]           dq_count;

  deque_result_t pending_results [$];
  stim_row_t     directed_rows [$];
  stim_row_t     cur_row;
  int            fail_count;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            hold_requests;
  int            hold_taken;
  int            cycle_count;

  circular_deque_core #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_popped_value (out_popped_value),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic deque_result_t apply_op(cdq_pkg::mode_t mode,
                                             logic [cdq_pkg::DATA_W-1:0] value);
    deque_result_t r;
    r.popped = '0;
    r.status = cdq_pkg::STATUS_OK;
    case (mode)
      cdq_pkg::MODE_PUSH_BACK, cdq_pkg::MODE_PUSH_FRONT: begin
        if (dq_count == DEPTH) begin
          r.status = cdq_pkg::STATUS_FULL;
        end else if (mode == cdq_pkg::MODE_PUSH_BACK) begin
          dq_mem[dq_tail] = value;
          dq_tail = dq_tail + 1'b1;
          dq_count = dq_count + 1'b1;
        end else begin
          dq_head = dq_head - 1'b1;
          dq_mem[dq_head] = value;
          dq_count = dq_count + 1'b1;
        end
      end
      default: begin
        if (dq_count == 0) begin
          r.status = cdq_pkg::STATUS_EMPTY;
        end else if (mode == cdq_pkg::MODE_POP_FRONT) begin
          r.popped = dq_mem[dq_head];
          dq_head = dq_head + 1'b1;
          dq_count = dq_count - 1'b1;
        end else begin
          dq_tail = dq_tail - 1'b1;
          r.popped = dq_mem[dq_tail];
          dq_count = dq_count - 1'b1;
        end
      end
    endcase
    r.count = dq_count;
    return r;
  endfunction

  function automatic void add_row(cdq_pkg::mode_t mode, logic [cdq_pkg::DATA_W-1:0] value,
                                  logic fixed, logic [cdq_pkg::DATA_W-1:0] popped,
                                  cdq_pkg::status_t status, logic [CNT_W-1:0] count);
    stim_row_t row;
    row.mode = mode;
    row.value = value;
    row.fixed = fixed;
    row.want.popped = popped;
    row.want.status = status;
    row.want.count = count;
    directed_rows.push_back(row);
  endfunction

  task automatic note_failure(string what, deque_result_t want);
    fail_count++;
    if (fail_count <= REPORT_MAX) begin
      $display("%0t: %s: expected popped %h status %0d count %0d, ",
               $realtime, what, want.popped, want.status, want.count,
               "got popped %h status %0d count %0d",
               out_popped_value, out_status, out_entry_count);
    end
  endtask

  always @(posedge clk) begin : check_and_predict
    deque_result_t want;
    deque_result_t predicted;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          want = '0;
          note_failure("result with no transaction pending", want);
        end else begin
          want = pending_results.pop_front();
          if (out_popped_value !== want.popped || out_status !== want.status ||
              out_entry_count !== want.count) begin
            note_failure("result mismatch", want);
          end
        end
      end
      if (in_valid && in_ready) begin
        predicted = apply_op(in_mode, in_value);
        pending_results.push_back(cur_row.fixed ? cur_row.want : predicted);
      end
    end
  end

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_taken < hold_requests) begin
        hold_taken++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_op(stim_row_t row);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    cur_row = row;
    in_mode <= row.mode;
    in_value <= row.value;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_random(int n, bit with_hold);
    stim_row_t row;
    int push_pct;
    int seg_left;
    int pick;
    push_pct = 50;
    seg_left = 0;
    for (int k = 0; k < n; k++) begin
      // Segments lean toward pushes, toward pops or toward neither, so the deque swings between empty and full.
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 40);
        pick = $urandom_range(0, 2);
        push_pct = (pick == 0) ? 15 : (pick == 1) ? 50 : 85;
      end
      seg_left--;
      if (with_hold && k == n / 2) hold_requests++;
      row.fixed = 1'b0;
      row.want = '0;
      if ($urandom_range(0, 99) < push_pct) begin
        if ($urandom_range(0, 1) != 0) begin
          row.mode = cdq_pkg::MODE_PUSH_FRONT;
        end else begin
          row.mode = cdq_pkg::MODE_PUSH_BACK;
        end
      end else begin
        if ($urandom_range(0, 1) != 0) begin
          row.mode = cdq_pkg::MODE_POP_BACK;
        end else begin
          row.mode = cdq_pkg::MODE_POP_FRONT;
        end
      end
      pick = $urandom_range(0, 9);
      row.value = (pick == 0) ? 32'h8000_0000 :
                  (pick == 1) ? 32'h7fff_ffff :
                  (pick == 2) ? 32'hffff_ffff :
                  (pick == 3) ? 32'h0000_0000 : 32'($urandom);
      send_op(row);
    end
  endtask

  initial begin : stimulus
    cdq_pkg::mode_t fill_mode;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = cdq_pkg::MODE_PUSH_BACK;
    in_value = '0;
    out_ready = 1'b0;
    cur_row = '0;
    fail_count = 0;
    hold_requests = 0;
    hold_taken = 0;
    send_idle_pct = 6;
    recv_idle_pct = 55;
    dq_head = '0;
    dq_tail = '0;
    dq_count = '0;
    for (int k = 0; k < DEPTH; k++) dq_mem[k] = '0;

    add_row(cdq_pkg::MODE_POP_FRONT,  32'h0000_0000, 1'b1, 32'h0000_0000,
            cdq_pkg::STATUS_EMPTY, CNT_W'(0));
    add_row(cdq_pkg::MODE_POP_BACK,   32'h1234_5678, 1'b1, 32'h0000_0000,
            cdq_pkg::STATUS_EMPTY, CNT_W'(0));
    add_row(cdq_pkg::MODE_PUSH_BACK,  32'h7fff_ffff, 1'b1, 32'h0000_0000,
            cdq_pkg::STATUS_OK, CNT_W'(1));
    add_row(cdq_pkg::MODE_PUSH_FRONT, 32'h8000_0000, 1'b1, 32'h0000_0000,
            cdq_pkg::STATUS_OK, CNT_W'(2));
    add_row(cdq_pkg::MODE_POP_BACK,   32'h0000_0000, 1'b1, 32'h7fff_ffff,
            cdq_pkg::STATUS_OK, CNT_W'(1));
    add_row(cdq_pkg::MODE_POP_FRONT,  32'h0000_0000, 1'b1, 32'h8000_0000,
            cdq_pkg::STATUS_OK, CNT_W'(0));
    add_row(cdq_pkg::MODE_POP_FRONT,  32'hffff_ffff, 1'b1, 32'h0000_0000,
            cdq_pkg::STATUS_EMPTY, CNT_W'(0));
    add_row(cdq_pkg::MODE_PUSH_FRONT, 32'hffff_ffff, 1'b1, 32'h0000_0000,
            cdq_pkg::STATUS_OK, CNT_W'(1));
    add_row(cdq_pkg::MODE_POP_BACK,   32'h0000_0000, 1'b1, 32'hffff_ffff,
            cdq_pkg::STATUS_OK, CNT_W'(0));
    for (int k = 0; k < DEPTH; k++) begin
      if ((k % 2) != 0) begin
        fill_mode = cdq_pkg::MODE_PUSH_FRONT;
      end else begin
        fill_mode = cdq_pkg::MODE_PUSH_BACK;
      end
      add_row(fill_mode, 32'h1111_1111 * k, 1'b0, '0, cdq_pkg::STATUS_OK, '0);
    end
    add_row(cdq_pkg::MODE_PUSH_BACK,  32'h5555_5555, 1'b1, 32'h0000_0000,
            cdq_pkg::STATUS_FULL, CNT_W'(16));
    add_row(cdq_pkg::MODE_PUSH_FRONT, 32'haaaa_aaaa, 1'b1, 32'h0000_0000,
            cdq_pkg::STATUS_FULL, CNT_W'(16));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) send_op(directed_rows[k]);
    run_random(RANDOM_ITEMS, 1'b1);
    drain_results();

    send_idle_pct = 55;
    recv_idle_pct = 6;
    run_random(RANDOM_ITEMS, 1'b0);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(RANDOM_ITEMS, 1'b0);
    drain_results();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
